// File: design/bmt_pkg.sv
// bmt_pkg: shared types for the breakpoint match table
`timescale 1ns / 1ps
`default_nettype none

package bmt_pkg;

  // command codes of an input item
  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_CHECK    = 1'b1;

  // one input item
  typedef struct packed {
    logic        cmd;
    logic [31:0] class_id;
    logic [31:0] method_id;
    logic [15:0] code_offset;
    logic [31:0] request_id;
  } item_t;

  // one result item
  typedef struct packed {
    logic        register_ok;
    logic        hit;
    logic [31:0] hit_request;
    logic        is_halted;
  } result_t;

  // one breakpoint entry as held in the slot memory
  typedef struct packed {
    logic [31:0] class_id;
    logic [31:0] method_id;
    logic [15:0] code_offset;
    logic [31:0] request_id;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  // controller to datapath commands
  typedef struct packed {
    logic load;         // capture the input item
    logic finish_reg;   // store the entry if room and report
    logic finish_miss;  // report no hit
    logic finish_hit;   // report a hit and set the halted flag
    logic idx_init;     // point the scan at the newest slot
    logic idx_dec;      // step the scan to the next older slot
    logic rd_en;        // read the slot under the scan pointer
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_check;
    logic halted;
    logic empty;
    logic match;
    logic idx_zero;
  } dp_status_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_READ   = 4'b0100,
    S_CMP    = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// File: design/breakpoint_match_table.sv
// breakpoint_match_table: top level of the breakpoint match table
//
// Usage: an item on item_i is taken at a clock edge with start_i high and
// busy_o low. A register item stores its location and request id in the next
// free slot; a check item compares the location with the used slots, newest
// first, and the first match reports its request id and sets the sticky
// halted flag. Checks while halted report no hit.
// Exactly one result per item appears on result_o for one cycle, marked by
// result_valid_o; the receiver takes it at the end of that cycle and has no
// means to hold it off.
// A register item, or a check while halted or with an empty table, is finished
// from the decide state; any other check steps through the used slots, newest
// first, reading one slot from the slot memory and then comparing it on the
// registered read data, until a match or the oldest slot. One item is in
// flight at a time;
// busy_o falls as the result strobe rises, so the next item may be taken in
// the cycle its predecessor's result is shown.
// Reset empties the table and clears the halted flag; no clearing pass runs,
// the slot memory is only read below the fill count.
`timescale 1ns / 1ps
`default_nettype none

module breakpoint_match_table #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire bmt_pkg::item_t   item_i,
  output bmt_pkg::result_t      result_o,
  output logic                  result_valid_o
);

  import bmt_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       ctrl_busy;

  // sequencing
  bmt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (ctrl_busy),
    .status_i (dp_status),
    .cmd_o    (dp_cmd)
  );

  // storage and compare
  bmt_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  assign busy_o = ctrl_busy;

endmodule

`default_nettype wire

// File: design/bmt_ram.sv
// bmt_ram: generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module bmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/bmt_ctrl.sv
// bmt_ctrl: state machine sequencing register and check items
`timescale 1ns / 1ps
`default_nettype none

module bmt_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire bmt_pkg::dp_status_t status_i,
  output bmt_pkg::dp_cmd_t         cmd_o
);

  import bmt_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!status_i.is_check) begin
          cmd_o.finish_reg = 1'b1;
          state_d          = S_IDLE;
        end else if (status_i.halted || status_i.empty) begin
          cmd_o.finish_miss = 1'b1;
          state_d           = S_IDLE;
        end else begin
          cmd_o.idx_init = 1'b1;
          state_d        = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        if (status_i.match) begin
          cmd_o.finish_hit = 1'b1;
          state_d          = S_IDLE;
        end else if (status_i.idx_zero) begin
          cmd_o.finish_miss = 1'b1;
          state_d           = S_IDLE;
        end else begin
          cmd_o.idx_dec = 1'b1;
          state_d       = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: design/bmt_datapath.sv
// bmt_datapath: slot memory, fill count, halted flag, scan pointer and result register
`timescale 1ns / 1ps
`default_nettype none

module bmt_datapath #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire bmt_pkg::item_t   item_i,
  input  wire bmt_pkg::dp_cmd_t cmd_i,
  output bmt_pkg::dp_status_t   status_o,
  output bmt_pkg::result_t      result_o,
  output logic                  result_valid_o
);

  import bmt_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  item_t           item_q;
  logic [CntW-1:0] used_q, used_d;
  logic            halt_q, halt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  result_t         result_q, result_d;
  logic            valid_q, valid_d;
  logic            full;
  logic            wr_en;
  slot_t           wr_slot;
  slot_t           rd_slot;

  // captured item, command and payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  assign full  = (used_q == CntW'(SLOTS));
  assign wr_en = cmd_i.finish_reg && !full;

  assign wr_slot.class_id    = item_q.class_id;
  assign wr_slot.method_id   = item_q.method_id;
  assign wr_slot.code_offset = item_q.code_offset;
  assign wr_slot.request_id  = item_q.request_id;

  // slot memory, written at the fill count, read at the scan pointer
  bmt_ram #(
    .Width (SlotW),
    .Depth (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (used_q[IdxW-1:0]),
    .wdata_i (wr_slot),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (rd_slot)
  );

  // fill count, halted flag and scan pointer
  always_comb begin
    used_d = used_q;
    halt_d = halt_q;
    idx_d  = idx_q;
    if (wr_en) begin
      used_d = used_q + CntW'(1);
    end
    if (cmd_i.finish_hit) begin
      halt_d = 1'b1;
    end
    if (cmd_i.idx_init) begin
      idx_d = IdxW'(used_q - CntW'(1));
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      halt_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      used_q <= used_d;
      halt_q <= halt_d;
      idx_q  <= idx_d;
    end
  end

  // result formation
  always_comb begin
    result_d             = result_q;
    valid_d              = 1'b0;
    if (cmd_i.finish_reg) begin
      result_d.register_ok = !full;
      result_d.hit         = 1'b0;
      result_d.hit_request = '0;
      result_d.is_halted   = halt_q;
      valid_d              = 1'b1;
    end else if (cmd_i.finish_miss) begin
      result_d.register_ok = 1'b0;
      result_d.hit         = 1'b0;
      result_d.hit_request = '0;
      result_d.is_halted   = halt_q;
      valid_d              = 1'b1;
    end else if (cmd_i.finish_hit) begin
      result_d.register_ok = 1'b0;
      result_d.hit         = 1'b1;
      result_d.hit_request = rd_slot.request_id;
      result_d.is_halted   = 1'b1;
      valid_d              = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // status to the controller
  assign status_o.is_check = (item_q.cmd == CMD_CHECK);
  assign status_o.halted   = halt_q;
  assign status_o.empty    = (used_q == '0);
  assign status_o.match    = (rd_slot.class_id == item_q.class_id) &&
                             (rd_slot.method_id == item_q.method_id) &&
                             (rd_slot.code_offset == item_q.code_offset);
  assign status_o.idx_zero = (idx_q == '0);

  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

// File: test/bmt_result_checker.sv
// bmt_result_checker: predicts and checks every result of the breakpoint match table
`timescale 1ns / 1ps

module bmt_result_checker #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             busy_i,
  input  wire bmt_pkg::item_t   item_i,
  input  wire bmt_pkg::result_t result_i,
  input  wire logic             result_valid_i,
  output int unsigned           pending_o,
  output int unsigned           mismatches_o
);

  import bmt_pkg::*;

  // shadow copy of the breakpoint table and the halted flag
  logic [31:0] bp_class   [SLOTS];
  logic [31:0] bp_method  [SLOTS];
  logic [15:0] bp_offset  [SLOTS];
  logic [31:0] bp_request [SLOTS];
  int unsigned bp_count;
  logic        bp_halted;

  result_t     awaited_q [$];
  result_t     oldest;
  result_t     predicted;
  int unsigned mismatch_count;

  initial begin
    bp_count       = 0;
    bp_halted      = 1'b0;
    mismatch_count = 0;
    pending_o      = 0;
    mismatches_o   = 0;
  end

  // apply one accepted item to the shadow table and work out its result
  function automatic result_t apply_item(input item_t it);
    result_t r;
    r = '0;
    if (it.cmd == CMD_REGISTER) begin
      if (bp_count < SLOTS) begin
        bp_class[bp_count]   = it.class_id;
        bp_method[bp_count]  = it.method_id;
        bp_offset[bp_count]  = it.code_offset;
        bp_request[bp_count] = it.request_id;
        bp_count++;
        r.register_ok = 1'b1;
      end
    end else if (!bp_halted) begin
      // newest slot first, first match wins
      for (int i = int'(bp_count) - 1; i >= 0; i--) begin
        if (!r.hit && bp_class[i] == it.class_id && bp_method[i] == it.method_id &&
            bp_offset[i] == it.code_offset) begin
          r.hit         = 1'b1;
          r.hit_request = bp_request[i];
        end
      end
      if (r.hit) bp_halted = 1'b1;
    end
    r.is_halted = bp_halted;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  // results are compared before the item taken at the same edge is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_i) begin
        if (awaited_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result transfer with none expected: %p", $time, result_i);
        end else begin
          oldest = awaited_q.pop_front();
          compare_field("register_ok", 32'(oldest.register_ok), 32'(result_i.register_ok));
          compare_field("hit", 32'(oldest.hit), 32'(result_i.hit));
          compare_field("hit_request", oldest.hit_request, result_i.hit_request);
          compare_field("is_halted", 32'(oldest.is_halted), 32'(result_i.is_halted));
        end
      end
      if (start_i && !busy_i) begin
        predicted = apply_item(item_i);
        awaited_q = {awaited_q, predicted};
      end
    end
    pending_o    <= awaited_q.size();
    mismatches_o <= mismatch_count;
  end

endmodule

// File: test/breakpoint_match_table_test.sv
// breakpoint_match_table_test: stimulus and verdict for the breakpoint match table
`timescale 1ns / 1ps

module breakpoint_match_table_test;
  import bmt_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PRE_HALT    = 600;
  localparam int unsigned POST_HALT   = 85;

  typedef struct packed {
    logic [31:0] cls;
    logic [31:0] mtd;
    logic [15:0] off;
  } spot_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  item_t       item_i;
  result_t     result_o;
  logic        result_valid_o;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned quiet_left;
  int unsigned placed_count;

  // locations known to be in the table, and a few reused ones for duplicates
  spot_t placed [SLOTS];
  spot_t pool   [4];

  breakpoint_match_table #(.SLOTS(SLOTS)) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  bmt_result_checker #(.SLOTS(SLOTS)) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .item_i         (item_i),
    .result_i       (result_o),
    .result_valid_i (result_valid_o),
    .pending_o      (pending),
    .mismatches_o   (mismatches)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL breakpoint_match_table");
      $finish;
    end
  end

  function automatic item_t compose(input logic cmd, input spot_t s, input logic [31:0] req);
    item_t it;
    it.cmd         = cmd;
    it.class_id    = s.cls;
    it.method_id   = s.mtd;
    it.code_offset = s.off;
    it.request_id  = req;
    return it;
  endfunction

  function automatic spot_t random_spot();
    spot_t s;
    s.cls = $urandom;
    s.mtd = $urandom;
    s.off = 16'($urandom_range(0, 16'hFFFF));
    return s;
  endfunction

  function automatic bit is_placed(input spot_t s);
    for (int unsigned i = 0; i < placed_count; i++) if (placed[i] == s) return 1'b1;
    return 1'b0;
  endfunction

  // one bit off a known location, never equal to a registered one
  function automatic spot_t nudge(input spot_t s);
    spot_t n;
    int unsigned pos;
    n   = s;
    pos = $urandom_range(0, 31);
    case ($urandom_range(0, 2))
      0:       n.cls = n.cls ^ (32'd1 << pos);
      1:       n.mtd = n.mtd ^ (32'd1 << pos);
      default: n.off = n.off ^ (16'd1 << (pos % 16));
    endcase
    while (is_placed(n)) n = random_spot();
    return n;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hand one item over and wait for its transfer
  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (it.cmd == CMD_REGISTER && placed_count < SLOTS) begin
      placed[placed_count] = '{it.class_id, it.method_id, it.code_offset};
      placed_count++;
    end
  endtask

  initial begin
    spot_t zeros;
    spot_t ones;
    spot_t s;
    int unsigned roll;

    zeros        = '0;
    ones         = '1;
    quiet_left   = 0;
    placed_count = 0;
    foreach (pool[i]) pool[i] = random_spot();
    start_i <= 1'b0;
    item_i  <= '0;
    rst_ni  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, extremes, duplicates, near misses
    send_item(compose(CMD_CHECK, zeros, 32'hFFFF_FFFF));
    send_item(compose(CMD_CHECK, ones, 32'h0));
    send_item(compose(CMD_REGISTER, zeros, 32'hFFFF_FFFF));
    send_item(compose(CMD_REGISTER, ones, 32'h0));
    send_item(compose(CMD_REGISTER, pool[0], 32'd1));
    send_item(compose(CMD_REGISTER, pool[0], 32'd2));
    send_item(compose(CMD_CHECK, '{32'h0, 32'h0, 16'h1}, $urandom));
    send_item(compose(CMD_CHECK, '{32'hFFFF_FFFE, 32'h7FFF_FFFF, 16'hFFFF}, $urandom));
    send_item(compose(CMD_CHECK, '{pool[0].cls, pool[0].mtd, pool[0].off ^ 16'h8000}, 0));
    send_item(compose(CMD_CHECK, '{pool[0].cls ^ 32'h1, pool[0].mtd, pool[0].off}, 0));

    // random, not yet halted: partial fill, checks that must all miss
    for (int n = 0; n < PRE_HALT; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25 && placed_count < 10) begin
        s = ($urandom_range(0, 1) == 0) ? pool[$urandom_range(0, 3)] : random_spot();
        send_item(compose(CMD_REGISTER, s, $urandom));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) s = nudge(placed[$urandom_range(0, placed_count - 1)]);
        else if (roll < 85) s = nudge(random_spot());
        else s = nudge(pool[$urandom_range(0, 3)]);
        send_item(compose(CMD_CHECK, s, $urandom));
      end
    end

    // a location registered several times: newest wins, then halted
    send_item(compose(CMD_CHECK, pool[0], $urandom));
    send_item(compose(CMD_CHECK, pool[0], $urandom));
    send_item(compose(CMD_CHECK, zeros, $urandom));

    // random while halted: fill the table past full, checks report no hit
    for (int n = 0; n < POST_HALT; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        s = ($urandom_range(0, 3) == 0) ? pool[$urandom_range(0, 3)] : random_spot();
        send_item(compose(CMD_REGISTER, s, $urandom));
      end else begin
        s = ($urandom_range(0, 2) != 0) ? placed[$urandom_range(0, placed_count - 1)]
                                        : random_spot();
        send_item(compose(CMD_CHECK, s, $urandom));
      end
    end
    send_item(compose(CMD_REGISTER, ones, 32'hFFFF_FFFF));
    start_i <= 1'b0;

    // drain, then allow for the longest scan
    while (pending != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 8) @(posedge clk_i);
    if (mismatches == 0)
      $display("PASS breakpoint_match_table");
    else
      $display("FAIL breakpoint_match_table");
    $finish;
  end

endmodule
